// ----- design/cht_pkg.sv -----
// cht_pkg: shared types, constants and hash helper for the coalesced hash table.
// No dependencies.
package cht_pkg;
  localparam int SLOTS = 256;
  localparam int IDX_W = 8;
  localparam int LINK_W = 9;
  localparam int KEY_BYTES = 8;
  localparam int HASH_SHL = 5;
  localparam int HASH_SHR = 2;
  localparam int QDEPTH = 2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_EXISTS = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // classified transaction passed from front to back
  typedef struct packed {
    logic        action;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] hash;
    logic [IDX_W-1:0] home;
    logic [31:0] value;
    logic [8:0]  size;
  } job_t;

  // slot record, one memory word
  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] hash;
    logic [31:0] value;
    logic [LINK_W-1:0] link;
  } slot_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_HASH, FE_MOD
  } fe_state_t;

  typedef enum logic [3:0] {
    BE_IDLE, BE_HREAD, BE_WALK, BE_PROBE, BE_PWAIT, BE_WRNEW, BE_WRHOME, BE_DONE
  } be_state_t;

  function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [7:0] b);
    hash_step = h ^ ((h << HASH_SHL) + (h >> HASH_SHR) + {56'd0, b});
  endfunction
endpackage

// ----- design/cht_ram.sv -----
// cht_ram: generic single-port RAM with registered read.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- design/cht_front.sv -----
// cht_front: accepts transactions, masks key, hashes one byte a cycle,
// reduces hash modulo table size one bit a cycle. Depends on cht_pkg.
module cht_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0] in_key_length,
  input  logic [31:0] in_value,
  input  logic [8:0] size,
  output logic job_valid,
  output cht_pkg::job_t job,
  input  logic job_ready
);
  import cht_pkg::*;
  fe_state_t st_r, st_nxt;
  job_t j_r, j_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [6:0] bit_r, bit_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [3:0] len;
  logic [63:0] mask;
  logic [9:0] sh;
  logic [7:0] b;

  always_comb begin
    len = (in_key_length > 4'd8) ? 4'd8 : in_key_length;
    mask = (len >= 4'd8) ? '1 : ((64'd1 << {len, 3'b000}) - 64'd1);
    b = 8'((j_r.key >> {cnt_r - 4'd1, 3'b000}) & 64'hFF);
    sh = {rem_r, j_r.hash[bit_r[5:0]]};
  end

  always_comb begin
    st_nxt = st_r;
    j_nxt = j_r;
    cnt_nxt = cnt_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    in_ready = 1'b0;
    job_valid = 1'b0;
    case (st_r)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          j_nxt.action = in_action;
          j_nxt.key = in_key_bytes & mask;
          j_nxt.len = len;
          j_nxt.hash = {60'd0, len};
          j_nxt.value = in_value;
          j_nxt.size = (size == 9'd0) ? 9'd1 : ((size > 9'(SLOTS)) ? 9'(SLOTS) : size);
          cnt_nxt = len;
          st_nxt = FE_HASH;
        end
      end
      FE_HASH: begin
        if (cnt_r == 4'd0) begin
          bit_nxt = 7'd63;
          rem_nxt = '0;
          st_nxt = FE_MOD;
        end else begin
          j_nxt.hash = hash_step(j_r.hash, b);
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      FE_MOD: begin
        if (bit_r[6]) begin
          j_nxt.home = IDX_W'(rem_r);
          job_valid = 1'b1;
          if (job_ready) st_nxt = FE_IDLE;
        end else begin
          rem_nxt = (sh >= {1'b0, j_r.size}) ? 9'(sh - {1'b0, j_r.size}) : sh[8:0];
          bit_nxt = bit_r - 7'd1;
        end
      end
      default: st_nxt = FE_IDLE;
    endcase
  end

  always_comb job = j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FE_IDLE;
    else st_r <= st_nxt;
    j_r <= j_nxt;
    cnt_r <= cnt_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
  end
endmodule

// ----- design/cht_queue.sv -----
// cht_queue: small FIFO of classified jobs between front and back.
// Depends on cht_pkg.
module cht_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cht_pkg::job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output cht_pkg::job_t rd_job
);
  import cht_pkg::*;
  job_t q_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  always_comb begin
    wr_ready = cnt_r != 2'(QDEPTH);
    rd_valid = cnt_r != 2'd0;
    rd_job = q_r[rp_r];
    push = wr_valid && wr_ready;
    pop = rd_valid && rd_ready;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_r[wp_r] <= wr_job;
  end
endmodule

// ----- design/cht_back.sv -----
// cht_back: walks chains, probes for empty slots, writes the slot memory.
// Depends on cht_pkg and cht_ram.
module cht_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  cht_pkg::job_t job,
  output logic res_strobe,
  output logic [2:0] res_status,
  output logic [31:0] res_value
);
  import cht_pkg::*;
  be_state_t st_r, st_nxt;
  job_t j_r, j_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt, emp_r, emp_nxt;
  logic [LINK_W-1:0] hlink_r, hlink_nxt, steps_r, steps_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [31:0] val_r, val_nxt;
  logic strobe_r, strobe_nxt;
  logic we;
  logic [IDX_W-1:0] ma;
  slot_t wd, rd;
  logic [LINK_W-1:0] rlink;
  logic hit;
  logic [IDX_W-1:0] emp_inc;

  cht_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(ma), .wdata(wd), .rdata(rd)
  );

  always_comb begin
    // only valid slots are read for links, and every valid slot has its link written
    rlink = rd.link;
    hit = rd.hash == j_r.hash && rd.key == j_r.key && rd.len == j_r.len;
    emp_inc = ({1'b0, emp_r} + 9'd1 == j_r.size) ? '0 : emp_r + IDX_W'(1);
  end

  always_comb begin
    st_nxt = st_r; j_nxt = j_r; valid_nxt = valid_r;
    addr_nxt = addr_r; emp_nxt = emp_r; hlink_nxt = hlink_r; steps_nxt = steps_r;
    stat_nxt = stat_r; val_nxt = val_r; strobe_nxt = 1'b0;
    we = 1'b0; ma = addr_r; wd = '0;
    job_ready = 1'b0;
    case (st_r)
      BE_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          j_nxt = job;
          addr_nxt = job.home;
          steps_nxt = '0;
          st_nxt = BE_HREAD;
        end
      end
      BE_HREAD: begin
        if (!valid_r[addr_r]) begin
          if (j_r.action == ACT_LOOKUP) begin
            stat_nxt = ST_NOT_FOUND; val_nxt = '0; st_nxt = BE_DONE;
          end else begin
            // an empty slot never carries a successor
            we = 1'b1;
            wd = '{key: j_r.key, len: j_r.len, hash: j_r.hash, value: j_r.value,
                   link: '0};
            valid_nxt[addr_r] = 1'b1;
            stat_nxt = ST_INSERTED; val_nxt = '0; st_nxt = BE_DONE;
          end
        end else begin
          st_nxt = BE_WALK; // read issued this cycle at addr_r
        end
      end
      BE_WALK: begin
        if (steps_r == '0) hlink_nxt = rlink;
        if (hit) begin
          stat_nxt = (j_r.action == ACT_LOOKUP) ? ST_FOUND : ST_EXISTS;
          val_nxt = (j_r.action == ACT_LOOKUP) ? rd.value : '0;
          st_nxt = BE_DONE;
        end else if (rlink == '0 || rlink > LINK_W'(SLOTS) ||
                     steps_r == LINK_W'(SLOTS - 1) ||
                     !valid_r[IDX_W'(rlink - LINK_W'(1))]) begin
          if (j_r.action == ACT_LOOKUP) begin
            stat_nxt = ST_NOT_FOUND; val_nxt = '0; st_nxt = BE_DONE;
          end else begin
            emp_nxt = j_r.home; steps_nxt = '0; st_nxt = BE_PROBE;
          end
        end else begin
          addr_nxt = IDX_W'(rlink - LINK_W'(1));
          ma = addr_nxt;
          steps_nxt = steps_r + LINK_W'(1);
          st_nxt = BE_WALK;
        end
      end
      BE_PROBE: begin
        if (!valid_r[emp_r]) begin
          ma = emp_r; st_nxt = BE_WRNEW;
        end else if (steps_r + LINK_W'(1) == j_r.size) begin
          stat_nxt = ST_FULL; val_nxt = '0; st_nxt = BE_DONE;
        end else begin
          emp_nxt = emp_inc; steps_nxt = steps_r + LINK_W'(1);
        end
      end
      BE_WRNEW: begin
        we = 1'b1; ma = emp_r;
        wd = '{key: j_r.key, len: j_r.len, hash: j_r.hash, value: j_r.value, link: hlink_r};
        valid_nxt[emp_r] = 1'b1;
        st_nxt = BE_PWAIT;
      end
      BE_PWAIT: begin
        ma = j_r.home; st_nxt = BE_WRHOME;
      end
      BE_WRHOME: begin
        we = 1'b1; ma = j_r.home;
        wd = rd;
        wd.link = {1'b0, emp_r} + LINK_W'(1);
        stat_nxt = ST_INSERTED; val_nxt = '0; st_nxt = BE_DONE;
      end
      BE_DONE: begin
        strobe_nxt = 1'b1; st_nxt = BE_IDLE;
      end
      default: st_nxt = BE_IDLE;
    endcase
    if (st_r == BE_IDLE && job_valid) ma = job.home;
  end

  always_comb begin
    res_strobe = strobe_r;
    res_status = stat_r;
    res_value = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BE_IDLE; valid_r <= '0; strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; strobe_r <= strobe_nxt;
    end
    j_r <= j_nxt; addr_r <= addr_nxt; emp_r <= emp_nxt; hlink_r <= hlink_nxt;
    steps_r <= steps_nxt; stat_r <= stat_nxt; val_r <= val_nxt;
  end
endmodule

// ----- design/coalesced_hash_table.sv -----
// coalesced_hash_table: top level, config register, front, queue, back.
// Depends on cht_pkg, cht_front, cht_queue, cht_back, cht_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | start & !busy      | in_action, in_key_bytes, in_key_length, in_value
//  out      | out_strobe (1 cyc) | out_status, out_found_value
//  cfg      | cfg_valid&cfg_ready| cfg_table_size
//
// Front: accept, then hashing of the key_length key bytes, then bit-serial
// modulo, then a queue of two. Back: one slot memory read per chain step;
// probe steps test the slot valid bits without a memory read; a linked insert
// writes the new slot, reads the home slot and rewrites its link.
// Transactions run one at a time.
// Reset clears slot valid bits at once; there is no clearing pass. The receiver
// cannot stall: each result is shown for one cycle on out_strobe.
module coalesced_hash_table (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_action,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0] in_key_length,
  input  logic signed [31:0] in_value,
  output logic out_strobe,
  output logic [2:0] out_status,
  output logic signed [31:0] out_found_value,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [8:0] cfg_table_size
);
  import cht_pkg::*;
  logic [8:0] size_r;
  logic f_ready, fj_valid, q_ready, q_valid, b_ready, pend_r;
  job_t fj, qj;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 9'd256;
    else if (cfg_valid && cfg_ready) size_r <= cfg_table_size;
  end
  assign cfg_ready = 1'b1;

  // one transaction in flight at a time
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (start && !busy) pend_r <= 1'b1;
    else if (out_strobe) pend_r <= 1'b0;
  end
  assign busy = pend_r || !f_ready;

  cht_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_ready(f_ready),
    .in_action(in_action), .in_key_bytes(in_key_bytes), .in_key_length(in_key_length),
    .in_value(in_value), .size(size_r), .job_valid(fj_valid), .job(fj), .job_ready(q_ready)
  );
  cht_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(q_ready), .wr_job(fj),
    .rd_valid(q_valid), .rd_ready(b_ready), .rd_job(qj)
  );
  cht_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_ready(b_ready), .job(qj),
    .res_strobe(out_strobe), .res_status(out_status),
    .res_value(out_found_value)
  );
endmodule
